### rtl/tlvp_pkg.sv
// Shared types, constants and helpers for the TLV datagram parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);
    localparam int LEN_W       = 15;

    localparam logic [7:0] TYPE_PAYLOAD = 8'd7;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNCATED = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_SHORT     = 2'd3
    } t_err;

    typedef struct packed {
        t_phase             phase;
        logic [7:0]         rtype;
        logic [7:0]         len_lo;
        logic [LEN_W-1:0]   rec_len;
        logic [LEN_W-1:0]   remaining;
        logic [31:0]        acc;
        logic [2:0]         offset;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_state;

    localparam t_state ST_RESET = '{
        phase: PH_TYPE, rtype: '0, len_lo: '0, rec_len: '0, remaining: '0,
        acc: '0, offset: '0, count: '0, dropped: 1'b0
    };

    typedef struct packed {
        t_phase           byte_kind;
        logic [7:0]       record_type;
        logic [LEN_W-1:0] record_length;
        logic [7:0]       value_byte;
        logic             payload_valid;
        logic             field_done;
        logic [31:0]      field_value;
        logic             record_end;
        logic             datagram_end;
        t_err             error_code;
    } t_result;

    // header field width in bytes, 0 for non-field types
    function automatic logic [2:0] field_width(input logic [7:0] t);
        logic [2:0] w;
        begin
            case (t)
                8'd1, 8'd2, 8'd5, 8'd6: w = 3'd2;
                8'd3, 8'd4:             w = 3'd4;
                default:                w = 3'd0;
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/tlv_datagram_parser.sv
// TLV datagram parser top level: parser state registers, step logic, result register.
// Depends on tlvp_pkg, tlvp_step, tlvp_out_reg.
//
//  channel | direction | handshake              | beat
//  in      | input     | i_in_valid / o_in_stall | one datagram byte + last flag
//  out     | output    | o_out_valid / i_out_stall | one tagged result per byte
//
// One byte per cycle unless stalled; result valid in the cycle after a beat is taken.
// The parser state and result register update in the same edge a beat is taken.
// Synchronous active-low reset clears the parser state and the result valid.
// o_in_stall rises only while a result is held and the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none

module tlv_datagram_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_byte_kind,
    output logic [7:0]       o_record_type,
    output logic [14:0]      o_record_length,
    output logic [7:0]       o_value_byte,
    output logic             o_payload_valid,
    output logic             o_field_done,
    output logic [31:0]      o_field_value,
    output logic             o_record_end,
    output logic             o_datagram_end,
    output logic [1:0]       o_error_code
);
    import tlvp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    t_result w_out;
    logic    w_accept;

    assign w_accept = i_in_valid & ~o_in_stall;

    tlvp_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_next      (n_state),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    tlvp_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_result     (w_result),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_full_stall (o_in_stall),
        .o_result     (w_out)
    );

    assign o_byte_kind     = w_out.byte_kind;
    assign o_record_type   = w_out.record_type;
    assign o_record_length = w_out.record_length;
    assign o_value_byte    = w_out.value_byte;
    assign o_payload_valid = w_out.payload_valid;
    assign o_field_done    = w_out.field_done;
    assign o_field_value   = w_out.field_value;
    assign o_record_end    = w_out.record_end;
    assign o_datagram_end  = w_out.datagram_end;
    assign o_error_code    = w_out.error_code;

`ifndef NO_ASSERTIONS
    a_done_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_done |-> o_record_end)
        else $error("field_done without record_end");

    a_payload_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_valid |-> o_byte_kind == PH_DATA
            && o_record_type == TYPE_PAYLOAD)
        else $error("payload flag on non-payload byte");

    a_dropped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_OVERFLOW |-> !o_field_done && !o_payload_valid)
        else $error("dropped record produced field or payload");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_last_byte |=> r_state.phase == PH_TYPE && r_state.count == '0)
        else $error("parser state not cleared after datagram end");
`endif

endmodule

`default_nettype wire

### rtl/tlvp_step.sv
// Per-beat parse logic: next parser state and result from current state and beat.
// Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_step (
    input  wire tlvp_pkg::t_state  i_state,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output tlvp_pkg::t_state       o_next,
    output tlvp_pkg::t_result      o_result
);
    import tlvp_pkg::*;

    logic [2:0]       w_fw;
    logic [LEN_W-1:0] w_eff_len;
    logic             w_room;
    logic             w_dropped;
    logic             w_take;
    logic [2:0]       w_off_upd;
    logic [31:0]      w_acc_upd;
    logic             w_data_end;

    assign w_fw       = field_width(i_state.rtype);
    assign w_eff_len  = i_data_byte[7] ? '0 : {i_data_byte[6:0], i_state.len_lo};
    assign w_room     = i_state.count < COUNT_W'(MAX_RECORDS);
    assign w_dropped  = (i_state.phase == PH_TYPE) ? !w_room : i_state.dropped;
    assign w_take     = i_state.offset < w_fw;
    assign w_off_upd  = w_take ? i_state.offset + 3'd1 : i_state.offset;
    assign w_data_end = i_state.remaining <= LEN_W'(1);

    always_comb begin
        w_acc_upd = i_state.acc;
        for (int i = 0; i < 4; i++) begin
            if (w_take && i_state.offset == 3'(i)) begin
                w_acc_upd[8*i +: 8] = i_data_byte;
            end
        end
    end

    // next state
    always_comb begin
        o_next = i_state;
        case (i_state.phase)
            PH_TYPE: begin
                o_next.rtype = i_data_byte;
                if (w_room) begin
                    o_next.count   = i_state.count + COUNT_W'(1);
                    o_next.dropped = 1'b0;
                end else begin
                    o_next.dropped = 1'b1;
                end
                o_next.phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                o_next.len_lo = i_data_byte;
                o_next.phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                o_next.rec_len   = w_eff_len;
                o_next.remaining = w_eff_len;
                o_next.acc       = '0;
                o_next.offset    = '0;
                o_next.phase     = (w_eff_len == '0) ? PH_TYPE : PH_DATA;
            end
            PH_DATA: begin
                o_next.acc    = w_acc_upd;
                o_next.offset = w_off_upd;
                if (i_state.remaining != '0) begin
                    o_next.remaining = i_state.remaining - LEN_W'(1);
                end
                if (w_data_end) begin
                    o_next.phase = PH_TYPE;
                end
            end
            default: o_next = i_state;
        endcase
        if (i_last_byte) begin
            o_next = ST_RESET;
        end
    end

    // result
    always_comb begin
        logic trunc;
        logic shortf;
        trunc  = 1'b0;
        shortf = 1'b0;
        o_result               = '0;
        o_result.byte_kind     = i_state.phase;
        o_result.record_type   = (i_state.phase == PH_TYPE) ? i_data_byte : i_state.rtype;
        o_result.value_byte    = i_data_byte;
        o_result.datagram_end  = i_last_byte;
        o_result.error_code    = ERR_NONE;
        case (i_state.phase)
            PH_TYPE, PH_LEN_LO: begin
                trunc = i_last_byte;
            end
            PH_LEN_HI: begin
                o_result.record_length = w_eff_len;
                if (w_eff_len == '0) begin
                    o_result.record_end = 1'b1;
                    if (w_fw != 3'd0 && !w_dropped) begin
                        o_result.field_done = 1'b1;
                        shortf              = 1'b1;
                    end
                end else begin
                    trunc = i_last_byte;
                end
            end
            PH_DATA: begin
                o_result.record_length = i_state.rec_len;
                o_result.payload_valid = (i_state.rtype == TYPE_PAYLOAD) && !w_dropped;
                if (w_data_end) begin
                    o_result.record_end = 1'b1;
                    if (w_fw != 3'd0 && !w_dropped) begin
                        o_result.field_done  = 1'b1;
                        o_result.field_value = w_acc_upd;
                        shortf               = w_off_upd < w_fw;
                    end
                end else begin
                    trunc = i_last_byte;
                end
            end
            default: trunc = 1'b0;
        endcase
        if (w_dropped) begin
            o_result.error_code = ERR_OVERFLOW;
        end else if (trunc) begin
            o_result.error_code = ERR_TRUNCATED;
        end else if (shortf) begin
            o_result.error_code = ERR_SHORT;
        end
    end

endmodule

`default_nettype wire

### rtl/tlvp_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire tlvp_pkg::t_result i_result,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_full_stall,
    output tlvp_pkg::t_result      o_result
);
    import tlvp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign n_valid      = i_load | (r_valid & i_out_stall);
    assign o_full_stall = r_valid & i_out_stall;
    assign o_out_valid  = r_valid;
    assign o_result     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
